// ===== hw/rtl/mmes_pkg.sv =====
// Shared types and constants of the multitrack MIDI event sequencer.
package mmes_pkg;

    localparam int unsigned IN_W  = 112;
    localparam int unsigned OUT_W = 32;

    localparam logic [2:0] OP_PLAY   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_PAUSE  = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;
    localparam logic [2:0] OP_STOP   = 3'd5;

    localparam logic [1:0] RES_MSG    = 2'd0;
    localparam logic [1:0] RES_REFILL = 2'd1;
    localparam logic [1:0] RES_RESET  = 2'd2;
    localparam logic [1:0] RES_LOOP   = 2'd3;

    localparam logic [3:0] EV_PROGRAM  = 4'd4;
    localparam logic [3:0] EV_PRESSURE = 4'd5;
    localparam logic [3:0] EV_BEND     = 4'd6;
    localparam logic [3:0] EV_TEMPO    = 4'd7;

    localparam logic [1:0] CFG_TPQ   = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_LOOP  = 2'd2;

    localparam logic [14:0] DEFAULT_TPQ   = 15'd96;
    localparam logic [23:0] DEFAULT_TEMPO = 24'd500000;
    localparam logic [23:0] RESET_TICK    = 24'd5208;
    localparam logic [9:0]  US_PER_MS     = 10'd1000;

    typedef struct packed {
        logic [23:0] tempo_value;
        logic [6:0]  param_two;
        logic [6:0]  param_one;
        logic [3:0]  channel;
        logic [3:0]  event_kind;
        logic [27:0] delta_ticks;
        logic        end_of_track;
        logic [4:0]  track;
        logic [31:0] now_ms;
    } in_data_t;

    typedef struct packed {
        logic [4:0] pad;
        logic [4:0] refill_track;
        logic [6:0] data_two;
        logic [6:0] data_one;
        logic [7:0] status_byte;
    } out_data_t;

    typedef struct packed {
        logic [23:0] tempo_value;
        logic [6:0]  param_two;
        logic [6:0]  param_one;
        logic [3:0]  channel;
        logic [3:0]  event_kind;
    } event_t;

endpackage

// ===== hw/rtl/mmes_ram.sv =====
// Generic single write port RAM with registered read.
module mmes_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/mmes_div.sv =====
// Restoring divider, one quotient bit per cycle.
module mmes_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [14:0] divisor,
    output logic        busy,
    output logic [23:0] quotient
);
    logic [15:0] rem_reg;
    logic [23:0] quo_reg;
    logic [14:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [15:0] shifted;
    logic        fits;

    assign shifted  = {rem_reg[14:0], quo_reg[23]};
    assign fits     = shifted >= {1'b0, dvs_reg};
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_reg <= {quo_reg[22:0], fits};
        end
    end
endmodule

// ===== hw/rtl/multitrack_midi_event_sequencer_core.sv =====
// Top level of the multitrack MIDI event sequencer.
// One input transfer is taken at a time; s_tready is high only while idle. Load, tick without
// scan, pause, resume and stop run no divide of their own, pause and stop also waiting for
// the output register. A scan walks the track time RAM one track at a time, and a tempo event
// adds a divide. Play and loop restart run the same divide and then give one refill transfer
// per track, each waiting on m_tready. No clearing pass is needed after reset.
module multitrack_midi_event_sequencer_core #(
    parameter int unsigned MAX_TRACKS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // now_ms, track, end_of_track, delta_ticks, event_kind, channel, param_one, param_two,
    // tempo_value
    input  logic [mmes_pkg::IN_W-1:0]  s_tdata,
    // op
    input  logic [2:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status_byte, data_one, data_two, refill_track, zero pad
    output logic [mmes_pkg::OUT_W-1:0] m_tdata,
    // result_kind
    output logic [1:0]                 m_tuser,
    output logic                       m_tlast,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [14:0]                cfg_data
);
    import mmes_pkg::*;

    localparam int unsigned D  = (MAX_TRACKS > 32) ? 32 : MAX_TRACKS;
    localparam int unsigned AW = (D > 1) ? $clog2(D) : 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DEC, ST_MARK, ST_DIV_GO, ST_DIV_WAIT, ST_FILL,
        ST_LD_RD, ST_LD_MUL, ST_LD_WR, ST_LD_POST,
        ST_SC_CUR, ST_SC_RD, ST_SC_CMP, ST_SC_END,
        ST_EV_RD, ST_EV_DEC, ST_ONE
    } state_t;

    state_t      state_reg;
    logic [2:0]  op_reg;
    in_data_t    in_reg;
    logic [14:0] tpq_reg;
    logic [5:0]  count_reg;
    logic        loop_reg;
    logic [D-1:0] done_reg;
    logic [D-1:0] vld_reg;
    logic [23:0] tick_reg;
    logic [31:0] start_reg;
    logic [31:0] pause_reg;
    logic [31:0] last_now_reg;
    logic        playing_reg;
    logic        paused_reg;
    logic        await_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] prod_reg;
    logic [31:0] cur_reg;
    logic [31:0] best_time_reg;
    logic [5:0]  best_reg;
    logic        found_reg;
    logic        div_tempo_reg;
    logic [23:0] div_arg_reg;
    logic [1:0]  res_kind_reg;
    out_data_t   res_data_reg;
    logic        res_last_reg;
    logic        m_valid_reg;
    out_data_t   m_data_reg;
    logic [1:0]  m_user_reg;
    logic        m_last_reg;

    logic [5:0]  n_act;
    logic [D-1:0] act_mask;
    logic        out_free;
    logic        out_load;
    logic [31:0] time_rdata;
    logic [31:0] time_val;
    logic [45:0] pend_rdata;
    event_t      ev;
    logic [14:0] divisor;
    logic        div_busy;
    logic [23:0] div_q;
    logic [AW-1:0] addr;
    logic        time_we;
    logic        pend_we;
    logic [31:0] time_wdata;
    event_t      pend_wdata;

    assign n_act    = (count_reg > 6'(D)) ? 6'(D) : count_reg;
    assign divisor  = (tpq_reg == '0) ? DEFAULT_TPQ : tpq_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign addr     = cnt_reg[AW-1:0];
    assign time_val = vld_reg[addr] ? time_rdata : 32'd0;
    assign ev       = event_t'(pend_rdata);
    assign time_we  = (state_reg == ST_LD_WR);
    assign pend_we  = (state_reg == ST_LD_RD);
    assign time_wdata = time_val + prod_reg;
    assign pend_wdata = '{tempo_value: in_reg.tempo_value, param_two: in_reg.param_two,
                          param_one: in_reg.param_one, channel: in_reg.channel,
                          event_kind: in_reg.event_kind};

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            act_mask[i] = (6'(i) < n_act);
        end
    end

    always_comb
    begin
        out_load = 1'b0;
        case (state_reg)
            ST_MARK, ST_FILL, ST_ONE: out_load = out_free;
            default: out_load = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    mmes_ram #(.WIDTH(32), .DEPTH(D)) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (addr),
        .wdata (time_wdata),
        .raddr (addr),
        .rdata (time_rdata)
    );

    mmes_ram #(.WIDTH(46), .DEPTH(D)) u_event_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (addr),
        .wdata (pend_wdata),
        .raddr (addr),
        .rdata (pend_rdata)
    );

    mmes_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIV_GO),
        .dividend (div_arg_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpq_reg   <= DEFAULT_TPQ;
            count_reg <= 6'd1;
            loop_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TPQ:   tpq_reg   <= cfg_data;
                CFG_COUNT: count_reg <= cfg_data[5:0];
                CFG_LOOP:  loop_reg  <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= res_data_reg;
            m_user_reg <= res_kind_reg;
            m_last_reg <= res_last_reg;
            if (state_reg == ST_FILL)
            begin
                m_data_reg <= '{pad: '0, refill_track: cnt_reg[4:0], data_two: '0,
                                data_one: '0, status_byte: '0};
                m_user_reg <= RES_REFILL;
                m_last_reg <= (cnt_reg == n_act - 6'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= '1;
            vld_reg      <= '0;
            tick_reg     <= RESET_TICK;
            start_reg    <= '0;
            pause_reg    <= '0;
            last_now_reg <= '0;
            playing_reg  <= 1'b0;
            paused_reg   <= 1'b0;
            await_reg    <= 1'b0;
            fill_reg     <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= s_tuser;
                        in_reg    <= in_data_t'(s_tdata);
                        state_reg <= ST_DEC;
                    end
                end
                ST_DEC:
                begin
                    state_reg <= ST_IDLE;
                    case (op_reg)
                        OP_PLAY:
                        begin
                            res_kind_reg <= RES_RESET;
                            res_data_reg <= '0;
                            res_last_reg <= (n_act == '0);
                            start_reg    <= in_reg.now_ms;
                            playing_reg  <= 1'b1;
                            paused_reg   <= 1'b0;
                            await_reg    <= 1'b0;
                            state_reg    <= ST_MARK;
                        end
                        OP_LOAD:
                        begin
                            if ({1'b0, in_reg.track} < n_act)
                            begin
                                cnt_reg <= {1'b0, in_reg.track};
                                if (in_reg.end_of_track)
                                begin
                                    done_reg[in_reg.track[AW-1:0]] <= 1'b1;
                                    state_reg <= ST_LD_POST;
                                end
                                else
                                begin
                                    done_reg[in_reg.track[AW-1:0]] <= 1'b0;
                                    state_reg <= ST_LD_RD;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            last_now_reg <= in_reg.now_ms;
                            if (playing_reg && !paused_reg && !await_reg && fill_reg == '0)
                            begin
                                state_reg <= ST_SC_CUR;
                            end
                        end
                        OP_PAUSE:
                        begin
                            if (playing_reg && !paused_reg)
                            begin
                                paused_reg   <= 1'b1;
                                pause_reg    <= in_reg.now_ms;
                                res_kind_reg <= RES_RESET;
                                res_data_reg <= '0;
                                res_last_reg <= 1'b1;
                                state_reg    <= ST_ONE;
                            end
                        end
                        OP_RESUME:
                        begin
                            if (playing_reg && paused_reg)
                            begin
                                start_reg  <= start_reg + (in_reg.now_ms - pause_reg);
                                paused_reg <= 1'b0;
                            end
                        end
                        OP_STOP:
                        begin
                            playing_reg  <= 1'b0;
                            await_reg    <= 1'b0;
                            fill_reg     <= '0;
                            res_kind_reg <= RES_RESET;
                            res_data_reg <= '0;
                            res_last_reg <= 1'b1;
                            state_reg    <= ST_ONE;
                        end
                        default: ;
                    endcase
                end
                ST_MARK:
                begin
                    if (out_free)
                    begin
                        div_arg_reg   <= DEFAULT_TEMPO;
                        div_tempo_reg <= 1'b0;
                        state_reg     <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (!div_busy)
                    begin
                        tick_reg <= div_q;
                        if (div_tempo_reg)
                        begin
                            state_reg <= ST_ONE;
                        end
                        else
                        begin
                            done_reg  <= done_reg & ~act_mask;
                            vld_reg   <= vld_reg & ~act_mask;
                            fill_reg  <= n_act;
                            cnt_reg   <= '0;
                            state_reg <= (n_act == '0) ? ST_IDLE : ST_FILL;
                        end
                    end
                end
                ST_FILL:
                begin
                    if (out_free)
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == n_act - 6'd1)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_LD_RD:
                begin
                    state_reg <= ST_LD_MUL;
                end
                ST_LD_MUL:
                begin
                    prod_reg  <= 32'(in_reg.delta_ticks * tick_reg);
                    state_reg <= ST_LD_WR;
                end
                ST_LD_WR:
                begin
                    vld_reg[addr] <= 1'b1;
                    state_reg     <= ST_LD_POST;
                end
                ST_LD_POST:
                begin
                    state_reg <= ST_IDLE;
                    if (fill_reg != '0)
                    begin
                        fill_reg <= fill_reg - 6'd1;
                    end
                    else if (await_reg)
                    begin
                        await_reg <= 1'b0;
                        if (playing_reg && !paused_reg)
                        begin
                            state_reg <= ST_SC_CUR;
                        end
                    end
                end
                ST_SC_CUR:
                begin
                    cur_reg   <= 32'((last_now_reg - start_reg) * US_PER_MS);
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= (n_act == '0) ? ST_SC_END : ST_SC_RD;
                end
                ST_SC_RD:
                begin
                    state_reg <= ST_SC_CMP;
                end
                ST_SC_CMP:
                begin
                    if (!done_reg[addr] &&
                        (!found_reg || $signed(time_val) < $signed(best_time_reg)))
                    begin
                        found_reg     <= 1'b1;
                        best_reg      <= cnt_reg;
                        best_time_reg <= time_val;
                    end
                    if (cnt_reg == n_act - 6'd1)
                    begin
                        state_reg <= ST_SC_END;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 6'd1;
                        state_reg <= ST_SC_RD;
                    end
                end
                ST_SC_END:
                begin
                    res_data_reg <= '0;
                    res_last_reg <= 1'b1;
                    if (!found_reg)
                    begin
                        if (loop_reg)
                        begin
                            res_kind_reg <= RES_LOOP;
                            res_last_reg <= (n_act == '0);
                            start_reg    <= last_now_reg;
                            state_reg    <= ST_MARK;
                        end
                        else
                        begin
                            playing_reg  <= 1'b0;
                            res_kind_reg <= RES_RESET;
                            state_reg    <= ST_ONE;
                        end
                    end
                    else if ($signed(best_time_reg) > $signed(cur_reg))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg   <= best_reg;
                        state_reg <= ST_EV_RD;
                    end
                end
                ST_EV_RD:
                begin
                    state_reg <= ST_EV_DEC;
                end
                ST_EV_DEC:
                begin
                    await_reg <= 1'b1;
                    res_last_reg <= 1'b1;
                    state_reg <= ST_ONE;
                    if (ev.event_kind <= EV_BEND)
                    begin
                        res_kind_reg <= RES_MSG;
                        res_data_reg <= '{pad: '0, refill_track: cnt_reg[4:0],
                            data_two: (ev.event_kind == EV_PROGRAM ||
                                       ev.event_kind == EV_PRESSURE) ? 7'd0 : ev.param_two,
                            data_one: ev.param_one,
                            status_byte: {1'b1, ev.event_kind[2:0], ev.channel}};
                    end
                    else
                    begin
                        res_kind_reg <= RES_REFILL;
                        res_data_reg <= '{pad: '0, refill_track: cnt_reg[4:0], data_two: '0,
                                          data_one: '0, status_byte: '0};
                        if (ev.event_kind == EV_TEMPO)
                        begin
                            div_arg_reg   <= ev.tempo_value;
                            div_tempo_reg <= 1'b1;
                            state_reg     <= ST_DIV_GO;
                        end
                    end
                end
                ST_ONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("input taken while busy");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DIV_WAIT))
        else $error("divider running outside its wait state");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(time_we && pend_we))
        else $error("both RAMs written at once");
`endif
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the multitrack MIDI event sequencer core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mmes_pkg::*;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [4:0] trk;
        logic       last;
    } midi_result_t;

    class midi_scoreboard;
        midi_result_t due_q[$];
        midi_result_t run_q[$];
        int errors;
        logic [14:0] tpq;
        logic [5:0]  count;
        logic        loop_en;
        event_t      pending[32];
        logic [31:0] due_time[32];
        logic        done[32];
        logic [23:0] tick_len;
        logic [31:0] start_ms;
        logic [31:0] pause_ms;
        logic [31:0] last_now;
        logic        playing;
        logic        paused;
        logic        awaiting;
        logic [4:0]  await_trk;
        int          fill;

        function new();
            errors = 0;
            tpq = DEFAULT_TPQ;
            count = 6'd1;
            loop_en = 1'b0;
            for (int t = 0; t < 32; t++)
            begin
                pending[t] = '0;
                due_time[t] = '0;
                done[t] = 1'b1;
            end
            tick_len = RESET_TICK;
            start_ms = '0;
            pause_ms = '0;
            last_now = '0;
            playing = 1'b0;
            paused = 1'b0;
            awaiting = 1'b0;
            await_trk = '0;
            fill = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [14:0] v);
            case (idx)
                CFG_TPQ:   tpq = v;
                CFG_COUNT: count = v[5:0];
                CFG_LOOP:  loop_en = v[0];
                default:   ;
            endcase
        endfunction

        function int tracks();
            return (count > 32) ? 32 : int'(count);
        endfunction

        function logic [23:0] tick_for(logic [23:0] tempo);
            logic [14:0] q;
            q = (tpq == 0) ? DEFAULT_TPQ : tpq;
            return tempo / q;
        endfunction

        function void add(logic [1:0] k, logic [7:0] s, logic [6:0] a, logic [6:0] b,
                          logic [4:0] trk);
            midi_result_t r;
            r.kind = k;
            r.status = s;
            r.d1 = a;
            r.d2 = b;
            r.trk = trk;
            r.last = 1'b0;
            run_q.push_back(r);
        endfunction

        function void rewind();
            tick_len = tick_for(DEFAULT_TEMPO);
            for (int t = 0; t < tracks(); t++)
            begin
                due_time[t] = '0;
                done[t] = 1'b0;
                add(RES_REFILL, 8'd0, 7'd0, 7'd0, 5'(t));
            end
            fill = tracks();
        endfunction

        function void scan();
            int best;
            logic [31:0] cur;
            event_t ev;
            logic [6:0] p2;
            best = -1;
            for (int t = 0; t < tracks(); t++)
                if (!done[t] && (best < 0 || $signed(due_time[t]) < $signed(due_time[best])))
                    best = t;
            if (best < 0)
            begin
                if (loop_en)
                begin
                    add(RES_LOOP, 8'd0, 7'd0, 7'd0, 5'd0);
                    rewind();
                    start_ms = last_now;
                end
                else
                begin
                    playing = 1'b0;
                    add(RES_RESET, 8'd0, 7'd0, 7'd0, 5'd0);
                end
                return;
            end
            cur = (last_now - start_ms) * 32'd1000;
            if ($signed(due_time[best]) > $signed(cur))
                return;
            ev = pending[best];
            awaiting = 1'b1;
            await_trk = 5'(best);
            if (ev.event_kind <= EV_BEND)
            begin
                p2 = (ev.event_kind == EV_PROGRAM || ev.event_kind == EV_PRESSURE)
                     ? 7'd0 : ev.param_two;
                add(RES_MSG, {1'b1, ev.event_kind[2:0], ev.channel}, ev.param_one, p2,
                    5'(best));
            end
            else
            begin
                if (ev.event_kind == EV_TEMPO)
                    tick_len = tick_for(ev.tempo_value);
                add(RES_REFILL, 8'd0, 7'd0, 7'd0, 5'(best));
            end
        endfunction

        function void note_input(logic [2:0] op, in_data_t d);
            logic [51:0] prod;
            run_q.delete();
            case (op)
                OP_PLAY:
                begin
                    add(RES_RESET, 8'd0, 7'd0, 7'd0, 5'd0);
                    rewind();
                    start_ms = d.now_ms;
                    playing = 1'b1;
                    paused = 1'b0;
                    awaiting = 1'b0;
                end
                OP_LOAD:
                begin
                    if (d.track < tracks())
                    begin
                        if (d.end_of_track)
                            done[d.track] = 1'b1;
                        else
                        begin
                            done[d.track] = 1'b0;
                            pending[d.track].event_kind = d.event_kind;
                            pending[d.track].channel = d.channel;
                            pending[d.track].param_one = d.param_one;
                            pending[d.track].param_two = d.param_two;
                            pending[d.track].tempo_value = d.tempo_value;
                            prod = d.delta_ticks * tick_len;
                            due_time[d.track] = due_time[d.track] + prod[31:0];
                        end
                        if (fill > 0)
                            fill--;
                        else if (awaiting)
                        begin
                            awaiting = 1'b0;
                            if (playing && !paused)
                                scan();
                        end
                    end
                end
                OP_TICK:
                begin
                    last_now = d.now_ms;
                    if (playing && !paused && !awaiting && fill == 0)
                        scan();
                end
                OP_PAUSE:
                begin
                    if (playing && !paused)
                    begin
                        paused = 1'b1;
                        pause_ms = d.now_ms;
                        add(RES_RESET, 8'd0, 7'd0, 7'd0, 5'd0);
                    end
                end
                OP_RESUME:
                begin
                    if (playing && paused)
                    begin
                        start_ms = start_ms + (d.now_ms - pause_ms);
                        paused = 1'b0;
                    end
                end
                OP_STOP:
                begin
                    playing = 1'b0;
                    awaiting = 1'b0;
                    fill = 0;
                    add(RES_RESET, 8'd0, 7'd0, 7'd0, 5'd0);
                end
                default: ;
            endcase
            if (run_q.size() > 0)
                run_q[$].last = 1'b1;
            foreach (run_q[i])
                due_q.push_back(run_q[i]);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", what);
        endtask

        task check_result(logic [1:0] kind, out_data_t od, logic last);
            midi_result_t e;
            if (due_q.size() == 0)
            begin
                report($sformatf("unexpected transfer, kind %0d", kind));
                return;
            end
            e = due_q.pop_front();
            if (kind !== e.kind)
                report($sformatf("kind %0d, want %0d", kind, e.kind));
            if (od.status_byte !== e.status)
                report($sformatf("status %h, want %h", od.status_byte, e.status));
            if (od.data_one !== e.d1)
                report($sformatf("data_one %h, want %h", od.data_one, e.d1));
            if (od.data_two !== e.d2)
                report($sformatf("data_two %h, want %h", od.data_two, e.d2));
            if (od.refill_track !== e.trk)
                report($sformatf("refill_track %0d, want %0d", od.refill_track, e.trk));
            if (last !== e.last)
                report($sformatf("tlast %b, want %b", last, e.last));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [2:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [14:0]       cfg_data;

    midi_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;
    int hold_left = 0;
    logic [31:0] wall = '0;

    multitrack_midi_event_sequencer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);

    // receiver: random stall modes, plus one long hold when requested
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task send_item(logic [2:0] op, in_data_t d);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_tdata <= d;
        s_tuser <= op;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, d);
        burst_left--;
        @(negedge clk);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.due_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [14:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    function automatic in_data_t make_event(int trk, bit eot, logic [27:0] delta,
                                            logic [3:0] kind, logic [3:0] ch,
                                            logic [6:0] p1, logic [6:0] p2,
                                            logic [23:0] tempo);
        in_data_t d;
        d = '0;
        d.now_ms = $urandom;
        d.track = 5'(trk);
        d.end_of_track = eot;
        d.delta_ticks = delta;
        d.event_kind = kind;
        d.channel = ch;
        d.param_one = p1;
        d.param_two = p2;
        d.tempo_value = tempo;
        return d;
    endfunction

    function automatic in_data_t at_time(logic [31:0] t);
        in_data_t d;
        d = '0;
        d.now_ms = t;
        return d;
    endfunction

    task next_item(output logic [2:0] op, output in_data_t d);
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 99);
        d = make_event($urandom, ($urandom_range(0, 9) == 0),
                       (k < 5) ? 28'($urandom) : 28'($urandom_range(0, 30)),
                       (k < 80) ? 4'($urandom_range(0, 6)) :
                       (k < 90) ? EV_TEMPO : 4'($urandom_range(8, 15)),
                       4'($urandom), 7'($urandom), 7'($urandom),
                       (k < 3) ? 24'hFFFFFF : (k < 6) ? 24'd0 : 24'($urandom));
        wall = ($urandom_range(0, 99) == 0) ? 32'($urandom)
                                            : wall + 32'($urandom_range(0, 40));
        if (sb.fill > 0 && r < 88)
        begin
            op = OP_LOAD;
            d.track = 5'(sb.tracks() - sb.fill);
            return;
        end
        if (sb.awaiting && r < 80)
        begin
            op = OP_LOAD;
            d.track = sb.await_trk;
            return;
        end
        d.now_ms = wall;
        if (!sb.playing && r < 60)
            op = OP_PLAY;
        else if (sb.paused && r < 50)
            op = OP_RESUME;
        else if (r < 85)
            op = OP_TICK;
        else if (r < 90)
            op = OP_PAUSE;
        else if (r < 93)
            op = OP_RESUME;
        else if (r < 94)
            op = OP_STOP;
        else if (r < 96)
            op = OP_PLAY;
        else if (r < 98)
            op = (sb.fill == 0) ? OP_LOAD : OP_TICK;
        else if (r < 99)
            op = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
        else
        begin
            op = OP_TICK;
            d.now_ms = $urandom;
        end
    endtask

    task run_phase(logic [14:0] tpq, logic [5:0] cnt, logic loop_en, int n, bit pressure);
        logic [2:0] op;
        in_data_t d;
        drain();
        write_reg(CFG_TPQ, tpq);
        write_reg(CFG_COUNT, 15'(cnt));
        write_reg(CFG_LOOP, 15'(loop_en));
        for (int i = 0; i < n; i++)
        begin
            if (pressure && i == 0)
            begin
                hold_left = HOLD_CYCLES;
                op = OP_PLAY;
                d = at_time(wall);
            end
            else
                next_item(op, d);
            send_item(op, d);
        end
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_reg(CFG_TPQ, 15'd0);
        write_reg(CFG_COUNT, 15'd2);
        write_reg(CFG_LOOP, 15'd0);
        send_item(OP_SPARE6, make_event(3, 1, '1, '1, '1, '1, '1, '1));
        send_item(OP_SPARE7, at_time(32'd7));
        send_item(OP_RESUME, at_time(32'd0));
        send_item(OP_PAUSE, at_time(32'd0));
        send_item(OP_TICK, at_time(32'd5));
        send_item(OP_STOP, at_time(32'd0));
        send_item(OP_PLAY, at_time(32'd100));
        send_item(OP_LOAD, make_event(0, 0, 28'd0, EV_PROGRAM, 4'hF, 7'h7F, 7'h7F, 24'd0));
        send_item(OP_LOAD, make_event(1, 0, 28'd0, EV_TEMPO, 4'h0, 7'h0, 7'h0, 24'hFFFFFF));
        send_item(OP_LOAD, make_event(7, 0, 28'd5, 4'd1, 4'h2, 7'h10, 7'h20, 24'd0));
        send_item(OP_TICK, at_time(32'd100));
        send_item(OP_LOAD, make_event(0, 0, '1, EV_BEND, 4'h3, 7'h00, 7'h7F, 24'd0));
        send_item(OP_LOAD, make_event(1, 1, 28'd0, 4'd8, 4'h0, 7'h0, 7'h0, 24'd0));
        send_item(OP_TICK, at_time(32'd101));
        send_item(OP_PAUSE, at_time(32'd102));
        send_item(OP_TICK, at_time(32'd103));
        send_item(OP_RESUME, at_time(32'd200));
        send_item(OP_TICK, at_time(32'hFFFFFFFF));
        send_item(OP_STOP, at_time(32'd0));

        run_phase(15'd96, 6'd4, 1'b1, 50, 1'b0);
        run_phase(15'd32767, 6'd32, 1'b0, 60, 1'b1);
        run_phase(15'd1, 6'd3, 1'b1, 50, 1'b0);
        run_phase(15'd0, 6'd63, 1'b1, 40, 1'b0);
        run_phase(15'd480, 6'd0, 1'b0, 15, 1'b0);
        run_phase(15'd0, 6'd0, 1'b1, 15, 1'b0);
        run_phase(15'($urandom), 6'($urandom_range(1, 32)), 1'($urandom), 70, 1'b0);
        run_phase(15'($urandom_range(1, 500)), 6'($urandom_range(1, 8)), 1'b1, 70, 1'b0);
        run_phase(15'($urandom), 6'($urandom_range(1, 32)), 1'b0, 70, 1'b0);
        drain();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
